>>> src/mrg_pkg.sv
`default_nettype none
package mrg_pkg;

  localparam int unsigned MAX_STOPS  = 7;
  localparam int unsigned FULL_SCALE = 100;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned COLOR_W = NUM_CH * CH_W;
  localparam int unsigned CNT_W   = 3;

  localparam int unsigned CFG_IDX_W = $clog2(MAX_STOPS + 1);
  localparam int unsigned STOP_AW   = $clog2(MAX_STOPS);

  // t = position * (stops - 1), at most FULL_SCALE * (MAX_STOPS - 1)
  localparam int unsigned T_W    = $clog2(FULL_SCALE * (MAX_STOPS - 1) + 1);
  localparam int unsigned FRAC_W = $clog2(FULL_SCALE + 1);
  localparam int unsigned PROD_W = CH_W + FRAC_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // x / 100 == (x * 5243) >> 19 for every x up to 255 * 100
  localparam int unsigned RECIP    = 5243;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned RECIP_SH = 19;
  localparam int unsigned QM_W     = SUM_W + RECIP_W;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_0     = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] STOP_COUNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] STOP_COUNT_MAX   = CNT_W'(MAX_STOPS);
  localparam logic [CNT_W-1:0] STOP_COUNT_RESET = CNT_W'(2);

  // segment and fraction handed from front to back
  typedef struct packed {
    logic [STOP_AW-1:0] seg;
    logic [FRAC_W-1:0]  frac;
  } seg_entry_t;

  // stop color write from the register block
  typedef struct packed {
    logic               en;
    logic [STOP_AW-1:0] addr;
    logic [COLOR_W-1:0] data;
  } stop_wr_t;

endpackage
`default_nettype wire

>>> src/mrg_pos_if.sv
`default_nettype none
interface mrg_pos_if;
  logic                        valid;
  logic                        ready;
  logic [mrg_pkg::POS_W-1:0]   position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface
`default_nettype wire

>>> src/mrg_rgb_if.sv
`default_nettype none
interface mrg_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [mrg_pkg::CH_W-1:0]   red;
  logic [mrg_pkg::CH_W-1:0]   green;
  logic [mrg_pkg::CH_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

>>> src/mrg_cfg_if.sv
`default_nettype none
interface mrg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mrg_pkg::CFG_IDX_W-1:0]   index;
  logic [mrg_pkg::COLOR_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/mrg_ram.sv
`default_nettype none
module mrg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

>>> src/mrg_fifo.sv
`default_nettype none
module mrg_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire mrg_pkg::seg_entry_t data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output mrg_pkg::seg_entry_t      data_o
);

  mrg_pkg::seg_entry_t               mem_q [mrg_pkg::FIFO_DEPTH];
  logic [mrg_pkg::FIFO_PW-1:0]       wptr_q, wptr_d;
  logic [mrg_pkg::FIFO_PW-1:0]       rptr_q, rptr_d;
  logic [mrg_pkg::FIFO_CW-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == mrg_pkg::FIFO_CW'(mrg_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == mrg_pkg::FIFO_PW'(mrg_pkg::FIFO_DEPTH - 1)) ? '0 :
               wptr_q + mrg_pkg::FIFO_PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == mrg_pkg::FIFO_PW'(mrg_pkg::FIFO_DEPTH - 1)) ? '0 :
               rptr_q + mrg_pkg::FIFO_PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + mrg_pkg::FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - mrg_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> src/mrg_cfg.sv
`default_nettype none
module mrg_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  mrg_cfg_if.sink                        cfg,
  output logic [mrg_pkg::CNT_W-1:0]      stop_cnt_o,
  output mrg_pkg::stop_wr_t              wr_o
);

  logic [mrg_pkg::CNT_W-1:0] stop_count_q, stop_count_d;

  assign cfg.ready = 1'b1;

  always_comb begin
    stop_count_d = stop_count_q;
    if (cfg.valid && cfg.index == mrg_pkg::REG_STOP_COUNT) begin
      stop_count_d = cfg.data[mrg_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= mrg_pkg::STOP_COUNT_RESET;
    end else begin
      stop_count_q <= stop_count_d;
    end
  end

  // out-of-range counts fold onto the nearest legal one
  always_comb begin
    priority if (stop_count_q < mrg_pkg::STOP_COUNT_MIN) begin
      stop_cnt_o = mrg_pkg::STOP_COUNT_MIN;
    end else if (stop_count_q > mrg_pkg::STOP_COUNT_MAX) begin
      stop_cnt_o = mrg_pkg::STOP_COUNT_MAX;
    end else begin
      stop_cnt_o = stop_count_q;
    end
  end

  always_comb begin
    wr_o.en   = cfg.valid && (cfg.index >= mrg_pkg::REG_STOP_0) &&
                ({1'b0, cfg.index} <= (mrg_pkg::CFG_IDX_W + 1)'(mrg_pkg::MAX_STOPS));
    wr_o.addr = mrg_pkg::STOP_AW'(cfg.index - mrg_pkg::REG_STOP_0);
    wr_o.data = cfg.data;
  end

endmodule
`default_nettype wire

>>> src/mrg_front.sv
`default_nettype none
module mrg_front (
  mrg_pos_if.sink                        pos,
  input  wire logic [mrg_pkg::CNT_W-1:0] stop_cnt_i,
  input  wire logic                      full_i,
  output logic                           push_o,
  output mrg_pkg::seg_entry_t            entry_o
);

  logic [mrg_pkg::POS_W-1:0]   pos_sat;
  logic [mrg_pkg::CNT_W-1:0]   cnt_m1;
  logic [mrg_pkg::T_W-1:0]     t;
  logic [mrg_pkg::STOP_AW-1:0] seg_raw;
  logic [mrg_pkg::STOP_AW-1:0] seg_max;
  logic [mrg_pkg::STOP_AW-1:0] seg;

  assign pos.ready = !full_i;
  assign push_o    = pos.valid && !full_i;

  always_comb begin
    pos_sat = (pos.position > mrg_pkg::POS_W'(mrg_pkg::FULL_SCALE)) ?
              mrg_pkg::POS_W'(mrg_pkg::FULL_SCALE) : pos.position;
    cnt_m1  = stop_cnt_i - mrg_pkg::CNT_W'(1);
    t       = mrg_pkg::T_W'(pos_sat) * mrg_pkg::T_W'(cnt_m1);

    // t / 100 by threshold compares, t stays below 100 * MAX_STOPS
    seg_raw = '0;
    for (int j = 1; j < mrg_pkg::MAX_STOPS; j++) begin
      if (t >= mrg_pkg::T_W'(j * mrg_pkg::FULL_SCALE)) begin
        seg_raw = mrg_pkg::STOP_AW'(j);
      end
    end

    // the last position lands on the end of the last segment
    seg_max = mrg_pkg::STOP_AW'(stop_cnt_i - mrg_pkg::CNT_W'(2));
    seg     = (seg_raw > seg_max) ? seg_max : seg_raw;

    entry_o.seg  = seg;
    entry_o.frac = mrg_pkg::FRAC_W'(t - mrg_pkg::T_W'(seg) *
                                        mrg_pkg::T_W'(mrg_pkg::FULL_SCALE));
  end

endmodule
`default_nettype wire

>>> src/mrg_back.sv
`default_nettype none
module mrg_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mrg_pkg::stop_wr_t   wr_i,
  input  wire logic                empty_i,
  input  wire mrg_pkg::seg_entry_t entry_i,
  output logic                     pop_o,
  mrg_rgb_if.source                rgb
);

  logic s1_adv, s2_adv, out_adv;
  logic s1_v_q, s2_v_q, out_v_q;

  logic [mrg_pkg::MAX_STOPS-1:0] stop_vld_q;

  logic [mrg_pkg::STOP_AW-1:0] seg_hi;
  logic [mrg_pkg::COLOR_W-1:0] rd_lo, rd_hi;
  logic [mrg_pkg::COLOR_W-1:0] col_lo, col_hi;

  logic [mrg_pkg::FRAC_W-1:0]  s1_frac_q;
  logic                        s1_vlo_q, s1_vhi_q;
  logic [mrg_pkg::FRAC_W-1:0]  w_lo;

  logic [mrg_pkg::PROD_W-1:0]  p_lo_d [mrg_pkg::NUM_CH];
  logic [mrg_pkg::PROD_W-1:0]  p_hi_d [mrg_pkg::NUM_CH];
  logic [mrg_pkg::PROD_W-1:0]  p_lo_q [mrg_pkg::NUM_CH];
  logic [mrg_pkg::PROD_W-1:0]  p_hi_q [mrg_pkg::NUM_CH];

  logic [mrg_pkg::SUM_W-1:0]   sum    [mrg_pkg::NUM_CH];
  logic [mrg_pkg::QM_W-1:0]    qm     [mrg_pkg::NUM_CH];
  logic [mrg_pkg::CH_W-1:0]    ch_d   [mrg_pkg::NUM_CH];
  logic [mrg_pkg::CH_W-1:0]    ch_q   [mrg_pkg::NUM_CH];

  // pipeline moves whenever the stage ahead frees up
  assign out_adv = !out_v_q || rgb.ready;
  assign s2_adv  = !s2_v_q || out_adv;
  assign s1_adv  = !s1_v_q || s2_adv;
  assign pop_o   = s1_adv && !empty_i;
  assign seg_hi  = entry_i.seg + mrg_pkg::STOP_AW'(1);

  mrg_ram #(
    .WIDTH (mrg_pkg::COLOR_W),
    .DEPTH (mrg_pkg::MAX_STOPS)
  ) u_stop_ram (
    .clk_i     (clk_i),
    .we_i      (wr_i.en),
    .waddr_i   (wr_i.addr),
    .wdata_i   (wr_i.data),
    .re_i      (s1_adv),
    .raddr_a_i (entry_i.seg),
    .raddr_b_i (seg_hi),
    .rdata_a_o (rd_lo),
    .rdata_b_o (rd_hi)
  );

  // stops never written read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_vld_q <= '0;
    end else if (wr_i.en) begin
      stop_vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= pop_o;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
      if (out_adv) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_frac_q <= entry_i.frac;
      s1_vlo_q  <= stop_vld_q[entry_i.seg];
      s1_vhi_q  <= stop_vld_q[seg_hi];
    end
  end

  always_comb begin
    col_lo = s1_vlo_q ? rd_lo : '0;
    col_hi = s1_vhi_q ? rd_hi : '0;
    w_lo   = mrg_pkg::FRAC_W'(mrg_pkg::FULL_SCALE) - s1_frac_q;
    for (int c = 0; c < mrg_pkg::NUM_CH; c++) begin
      // channel 0 is red in the top byte
      p_lo_d[c] = mrg_pkg::PROD_W'(col_lo[(mrg_pkg::NUM_CH - 1 - c) * mrg_pkg::CH_W +:
                                          mrg_pkg::CH_W]) * mrg_pkg::PROD_W'(w_lo);
      p_hi_d[c] = mrg_pkg::PROD_W'(col_hi[(mrg_pkg::NUM_CH - 1 - c) * mrg_pkg::CH_W +:
                                          mrg_pkg::CH_W]) * mrg_pkg::PROD_W'(s1_frac_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      p_lo_q <= p_lo_d;
      p_hi_q <= p_hi_d;
    end
  end

  // divide by 100 through the reciprocal
  always_comb begin
    for (int c = 0; c < mrg_pkg::NUM_CH; c++) begin
      sum[c]  = mrg_pkg::SUM_W'(p_lo_q[c]) + mrg_pkg::SUM_W'(p_hi_q[c]);
      qm[c]   = mrg_pkg::QM_W'(sum[c]) * mrg_pkg::QM_W'(mrg_pkg::RECIP);
      ch_d[c] = qm[c][mrg_pkg::RECIP_SH +: mrg_pkg::CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      ch_q <= ch_d;
    end
  end

  assign rgb.valid = out_v_q;
  assign rgb.red   = ch_q[0];
  assign rgb.green = ch_q[1];
  assign rgb.blue  = ch_q[2];

endmodule
`default_nettype wire

>>> src/multi_stop_rgb_gradient.sv
// An accepted position beat passes the queue, then the RAM read, multiply and
// output registers. Throughput: one beat per cycle unless the output stalls; the
//   back end (RAM read, multiply, reciprocal divide) takes one segment per cycle.
// A 2-entry queue decouples position intake from the result handshake.
// Reset (rst_ni, async low): stop count 2, all stops read as black.
`default_nettype none
module multi_stop_rgb_gradient (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mrg_pos_if.sink   pos_i,
  mrg_rgb_if.source rgb_o,
  mrg_cfg_if.sink   cfg_i
);

  logic [mrg_pkg::CNT_W-1:0] stop_cnt;
  mrg_pkg::stop_wr_t         stop_wr;
  logic                      push, full, pop, empty;
  mrg_pkg::seg_entry_t       push_entry, pop_entry;

  mrg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg        (cfg_i),
    .stop_cnt_o (stop_cnt),
    .wr_o       (stop_wr)
  );

  mrg_front u_front (
    .pos        (pos_i),
    .stop_cnt_i (stop_cnt),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  mrg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_entry)
  );

  mrg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (stop_wr),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .rgb     (rgb_o)
  );

endmodule
`default_nettype wire
